// ----- rtl/core/tbd_pkg.sv -----
`default_nettype none

package tbd_pkg;

    localparam int MAX_PERIOD  = 32;
    localparam int KEY_LEN     = 27;
    localparam int KEY_W       = KEY_LEN * 8;
    localparam int KEY_IDX_W   = 5;
    localparam int PERIOD_W    = $clog2(MAX_PERIOD + 1);
    localparam int STORE_DEPTH = 3 * MAX_PERIOD;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int CFG_AW      = 6;
    localparam int CFG_DW      = 64;
    localparam int PER_REG_W   = 6;
    localparam int TAIL_W      = 24;

    // register indexes (byte address / 8)
    localparam logic [2:0] REG_KEY_LOW  = 3'd0;
    localparam logic [2:0] REG_KEY_MID  = 3'd1;
    localparam logic [2:0] REG_KEY_HIGH = 3'd2;
    localparam logic [2:0] REG_KEY_TAIL = 3'd3;
    localparam logic [2:0] REG_PERIOD   = 3'd4;

    localparam logic [PER_REG_W-1:0] PERIOD_RESET = 6'd5;

    localparam logic [7:0] HASH_CHAR = 8'h23;
    localparam logic [7:0] X_CHAR    = 8'h78;

    // digit row selectors
    localparam logic [1:0] DIG_TOP = 2'd0;
    localparam logic [1:0] DIG_MID = 2'd1;
    localparam logic [1:0] DIG_LOW = 2'd2;

    typedef logic [1:0] digit_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;

    typedef struct packed {
        digit_t d0;
        digit_t d1;
        digit_t d2;
    } digits_t;

    typedef struct packed {
        logic       load_item;
        logic       wr_en;
        logic [1:0] wr_sel;
        logic       fill_inc;
        logic       clear_block;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_r0;
        logic       cap_r1;
        logic       out_load;
        logic       col_inc;
    } ctrl_cmd_t;

    typedef struct packed {
        logic block_full;
        logic item_end;
        logic last_col;
        logic out_free;
    } dp_status_t;

    function automatic digits_t split_index(input key_idx_t k);
        digits_t  d;
        key_idx_t m;
        if (k >= 5'd18)
        begin
            d.d0 = 2'd2;
            m    = k - 5'd18;
        end
        else if (k >= 5'd9)
        begin
            d.d0 = 2'd1;
            m    = k - 5'd9;
        end
        else
        begin
            d.d0 = 2'd0;
            m    = k;
        end
        if (m >= 5'd6)
        begin
            d.d1 = 2'd2;
            d.d2 = 2'(m - 5'd6);
        end
        else if (m >= 5'd3)
        begin
            d.d1 = 2'd1;
            d.d2 = 2'(m - 5'd3);
        end
        else
        begin
            d.d1 = 2'd0;
            d.d2 = 2'(m);
        end
        return d;
    endfunction

    function automatic key_idx_t join_digits(input digits_t d);
        return 5'(d.d0) * 5'd9 + 5'(d.d1) * 5'd3 + 5'(d.d2);
    endfunction

    function automatic logic [7:0] key_byte(input key_t key, input key_idx_t idx);
        logic [7:0] b;
        if (idx < 5'(KEY_LEN))
            b = key[8 * idx +: 8];
        else
            b = key[7:0];
        return b;
    endfunction

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PER_REG_W-1:0] p);
        logic [PERIOD_W-1:0] e;
        if (p == '0)
            e = PERIOD_W'(1);
        else if (int'(p) > MAX_PERIOD)
            e = PERIOD_W'(MAX_PERIOD);
        else
            e = PERIOD_W'(p);
        return e;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tbd_ram.sv -----
`default_nettype none

module tbd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/tbd_regs.sv -----
`default_nettype none

module tbd_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tbd_pkg::CFG_AW-1:0]     paddr,
    input  wire logic [tbd_pkg::CFG_DW-1:0]     pwdata,
    output logic      [tbd_pkg::CFG_DW-1:0]     prdata,
    output tbd_pkg::key_t                       key,
    output logic      [tbd_pkg::PER_REG_W-1:0]  period_raw,
    output logic                                period_wr
);

    logic [tbd_pkg::CFG_DW-1:0]    key_low_reg;
    logic [tbd_pkg::CFG_DW-1:0]    key_mid_reg;
    logic [tbd_pkg::CFG_DW-1:0]    key_high_reg;
    logic [tbd_pkg::TAIL_W-1:0]    key_tail_reg;
    logic [tbd_pkg::PER_REG_W-1:0] period_reg;
    logic                          wr;
    logic [2:0]                    sel;

    assign wr  = psel && penable && pwrite;
    assign sel = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_mid_reg  <= '0;
            key_high_reg <= '0;
            key_tail_reg <= '0;
            period_reg   <= tbd_pkg::PERIOD_RESET;
        end
        else if (wr)
        begin
            unique case (sel)
                tbd_pkg::REG_KEY_LOW:  key_low_reg  <= pwdata;
                tbd_pkg::REG_KEY_MID:  key_mid_reg  <= pwdata;
                tbd_pkg::REG_KEY_HIGH: key_high_reg <= pwdata;
                tbd_pkg::REG_KEY_TAIL: key_tail_reg <= pwdata[tbd_pkg::TAIL_W-1:0];
                tbd_pkg::REG_PERIOD:   period_reg   <= pwdata[tbd_pkg::PER_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            tbd_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            tbd_pkg::REG_KEY_MID:  prdata = key_mid_reg;
            tbd_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            tbd_pkg::REG_KEY_TAIL: prdata = tbd_pkg::CFG_DW'(key_tail_reg);
            tbd_pkg::REG_PERIOD:   prdata = tbd_pkg::CFG_DW'(period_reg);
            default:               prdata = '0;
        endcase
    end

    assign key        = {key_tail_reg, key_high_reg, key_mid_reg, key_low_reg};
    assign period_raw = period_reg;
    assign period_wr  = wr && (sel == tbd_pkg::REG_PERIOD);

endmodule

`default_nettype wire

// ----- rtl/core/tbd_ctrl.sv -----
`default_nettype none

module tbd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tbd_pkg::dp_status_t status,
    output tbd_pkg::ctrl_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR0  = 3'd1;
    localparam logic [2:0] S_WR1  = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_RD0  = 3'd4;
    localparam logic [2:0] S_RD1  = 3'd5;
    localparam logic [2:0] S_RD2  = 3'd6;
    localparam logic [2:0] S_RD3  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_WR0;
                end
            end
            S_WR0:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tbd_pkg::DIG_TOP;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = tbd_pkg::DIG_MID;
                state_next = S_WR2;
            end
            S_WR2:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = tbd_pkg::DIG_LOW;
                cmd.fill_inc = 1'b1;
                if (status.block_full)
                    state_next = S_RD0;
                else
                begin
                    // drop a partial block at message end
                    cmd.clear_block = status.item_end;
                    state_next      = S_IDLE;
                end
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tbd_pkg::DIG_TOP;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tbd_pkg::DIG_MID;
                cmd.cap_r0 = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = tbd_pkg::DIG_LOW;
                cmd.cap_r1 = 1'b1;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                // hold here with the low digit on the store output until the beat slot frees
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.last_col)
                    begin
                        cmd.clear_block = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.col_inc = 1'b1;
                        state_next  = S_RD0;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/tbd_datapath.sv -----
`default_nettype none

module tbd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tbd_pkg::ctrl_cmd_t            cmd,
    output tbd_pkg::dp_status_t                status,
    input  wire tbd_pkg::key_t                 key,
    input  wire logic [tbd_pkg::PER_REG_W-1:0] period_raw,
    input  wire logic                          period_wr,
    input  wire logic [7:0]                    in_byte,
    input  wire logic                          in_end,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic      [7:0]                    out_byte,
    output logic                               out_last,
    output logic                               out_bad
);

    localparam int PW = tbd_pkg::PERIOD_W;
    localparam int AW = tbd_pkg::STORE_AW;

    logic [PW-1:0]          period;
    logic                   found;
    tbd_pkg::key_idx_t      k_hit;
    logic                   clear;

    // item payload
    tbd_pkg::digits_t       digits_reg;
    logic                   end_reg;
    // block control state
    logic [PW-1:0]          fill_reg;
    logic [PW-1:0]          fill_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic [AW-1:0]          wr_ptr_reg;
    logic [AW-1:0]          wr_ptr_next;
    logic [PW-1:0]          col_reg;
    logic [PW-1:0]          col_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    // read side payload
    tbd_pkg::digit_t        r0_reg;
    tbd_pkg::digit_t        r1_reg;
    logic [7:0]             out_byte_reg;
    logic                   out_last_reg;
    logic                   out_bad_reg;

    tbd_pkg::digit_t        wdata;
    logic [AW-1:0]          raddr;
    tbd_pkg::digit_t        rdata;
    tbd_pkg::digits_t       col_digits;
    logic [7:0]             plain;

    assign period = tbd_pkg::eff_period(period_raw);
    assign clear  = cmd.clear_block || period_wr;

    // first matching key position wins
    always_comb
    begin
        found = 1'b0;
        k_hit = '0;
        for (int i = tbd_pkg::KEY_LEN - 1; i >= 0; i--)
        begin
            if (key[8 * i +: 8] == in_byte)
            begin
                found = 1'b1;
                k_hit = 5'(i);
            end
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            tbd_pkg::DIG_TOP: wdata = digits_reg.d0;
            tbd_pkg::DIG_MID: wdata = digits_reg.d1;
            default:          wdata = digits_reg.d2;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            tbd_pkg::DIG_TOP: raddr = AW'(col_reg);
            tbd_pkg::DIG_MID: raddr = AW'(col_reg) + AW'(period);
            default:          raddr = AW'(col_reg) + (AW'(period) << 1);
        endcase
    end

    tbd_ram #(
        .WIDTH (2),
        .DEPTH (tbd_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_ptr_reg),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign col_digits = '{d0: r0_reg, d1: r1_reg, d2: rdata};

    always_comb
    begin
        plain = tbd_pkg::key_byte(key, tbd_pkg::join_digits(col_digits));
        if (plain == tbd_pkg::HASH_CHAR)
            plain = tbd_pkg::X_CHAR;
    end

    always_comb
    begin
        fill_next      = fill_reg;
        bad_next       = bad_reg;
        wr_ptr_next    = wr_ptr_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_item && !found)
            bad_next = 1'b1;
        if (cmd.wr_en)
            wr_ptr_next = wr_ptr_reg + AW'(1);
        if (cmd.fill_inc)
            fill_next = fill_reg + PW'(1);
        if (cmd.col_inc)
            col_next = col_reg + PW'(1);
        if (clear)
        begin
            fill_next   = '0;
            bad_next    = 1'b0;
            wr_ptr_next = '0;
            col_next    = '0;
        end
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            bad_reg       <= 1'b0;
            wr_ptr_reg    <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            bad_reg       <= bad_next;
            wr_ptr_reg    <= wr_ptr_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            digits_reg <= tbd_pkg::split_index(k_hit);
            end_reg    <= in_end;
        end
        if (cmd.cap_r0)
            r0_reg <= rdata;
        if (cmd.cap_r1)
            r1_reg <= rdata;
        if (cmd.out_load)
        begin
            out_byte_reg <= plain;
            out_last_reg <= status.last_col;
            out_bad_reg  <= bad_reg;
        end
    end

    assign status.block_full = (fill_reg + PW'(1) == period);
    assign status.item_end   = end_reg;
    assign status.last_col   = (col_reg + PW'(1) == period);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

endmodule

`default_nettype wire

// ----- rtl/core/trifid_block_decipher.sv -----
// A symbol is accepted and looked up in S_IDLE; S_WR0, S_WR1, S_WR2 write its digits to the store.
// A completing symbol then emits its block one result at a time: S_RD0..S_RD2 read the store,
// one digit per access, and S_RD3 loads the result once the output beat slot is free.
// rst_n (async, active low) clears control state, key registers to 0 and the period to 5;
// the digit store is not cleared and needs no pass after reset.
`default_nettype none

module trifid_block_decipher (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] cipher_byte
    input  wire logic                          s_tlast,   // message_end
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [7:0]                    m_tdata,   // [7:0] plain_byte
    output logic                               m_tlast,   // block_last
    output logic                               m_tuser,   // [0] bad_symbol
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tbd_pkg::CFG_AW-1:0]    paddr,
    input  wire logic [tbd_pkg::CFG_DW-1:0]    pwdata,
    output logic      [tbd_pkg::CFG_DW-1:0]    prdata,
    output logic                               pready
);

    tbd_pkg::key_t                  key;
    logic [tbd_pkg::PER_REG_W-1:0]  period_raw;
    logic                           period_wr;
    tbd_pkg::ctrl_cmd_t             cmd;
    tbd_pkg::dp_status_t            status;

    assign pready = 1'b1;

    tbd_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .key        (key),
        .period_raw (period_raw),
        .period_wr  (period_wr)
    );

    tbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbd_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .key        (key),
        .period_raw (period_raw),
        .period_wr  (period_wr),
        .in_byte    (s_tdata),
        .in_end     (s_tlast),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (m_tdata),
        .out_last   (m_tlast),
        .out_bad    (m_tuser)
    );

    // a result never overwrites a beat that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over a pending beat");

    // no new symbol while the store is being written or a block is being read out
    a_no_accept_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd_en || cmd.wr_en) |-> !s_tready)
        else $error("input ready during store access");

    // an accepted symbol starts its digit writes on the next cycle
    a_write_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (cmd.wr_en && !s_tready))
        else $error("symbol accepted without store write");

    // the store is never read and written in the same cycle
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("store read and write collide");

endmodule

`default_nettype wire
